### hdl/row_column_projection_counter_defines.svh
// Assertion helpers used by rcpc_back.
`ifndef ROW_COLUMN_PROJECTION_COUNTER_DEFINES_SVH
`define ROW_COLUMN_PROJECTION_COUNTER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define RCPC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define RCPC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/rcpc_pkg.sv
package rcpc_pkg;

  // Field widths
  localparam int COUNT_W    = 11;
  localparam int MASS_W     = 21;
  localparam int ROW_IDX_W  = 10;
  localparam int PIX_W      = 8;
  localparam int COL_IDX_W  = 10;
  localparam int CENTER_W   = 10;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // Saturation limits
  localparam logic [COUNT_W-1:0] COUNT_SAT = 11'd1024;
  localparam logic [MASS_W-1:0]  MASS_SAT  = 21'd1048576;

  // Operation codes; the fourth code is a no-op
  localparam logic [OP_W-1:0] OP_PIXEL = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y  = 3'd4;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET     = 11'd640;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET    = 11'd480;
  localparam logic [PIX_W-1:0]      THRESHOLD_RESET = 8'd10;
  localparam logic [CENTER_W-1:0]   CENTER_RESET    = 10'd0;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  // Classified transaction handed from front to back
  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic                 lit;
    logic                 row_end;
    logic                 frame_end;
    logic                 upper;
    logic                 left;
    logic                 in_range;
    logic [ROW_IDX_W-1:0] row_index;
  } entry_t;

  function automatic logic [COUNT_W-1:0] sat_count(input logic [COUNT_W-1:0] v);
    return (v < COUNT_SAT) ? v + COUNT_W'(1) : COUNT_SAT;
  endfunction

  function automatic logic [MASS_W-1:0] sat_mass(input logic [MASS_W-1:0] v);
    return (v < MASS_SAT) ? v + MASS_W'(1) : MASS_SAT;
  endfunction

endpackage

### hdl/rcpc_front.sv
module rcpc_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [rcpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rcpc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                accept,
  input  logic [rcpc_pkg::OP_W-1:0]           op,
  input  logic [rcpc_pkg::PIX_W-1:0]          pixel,
  input  logic [rcpc_pkg::COL_IDX_W-1:0]      column_index,
  output rcpc_pkg::entry_t                    entry,
  output logic [$clog2(MAX_WIDTH)-1:0]        addr
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int WCW = (XW + 1 > rcpc_pkg::CFG_DATA_W) ? XW + 1 : rcpc_pkg::CFG_DATA_W;
  localparam int HCW = (YW + 1 > rcpc_pkg::CFG_DATA_W) ? YW + 1 : rcpc_pkg::CFG_DATA_W;
  localparam int XCW = (XW > rcpc_pkg::CENTER_W) ? XW : rcpc_pkg::CENTER_W;
  localparam int YCW = (YW > rcpc_pkg::CENTER_W) ? YW : rcpc_pkg::CENTER_W;

  logic [rcpc_pkg::CFG_DATA_W-1:0] width_in_use;
  logic [rcpc_pkg::CFG_DATA_W-1:0] height_in_use;
  logic [rcpc_pkg::PIX_W-1:0]      lit_threshold;
  logic [rcpc_pkg::CENTER_W-1:0]   center_x;
  logic [rcpc_pkg::CENTER_W-1:0]   center_y;

  logic [XW-1:0] col_pos;
  logic [YW-1:0] row_pos;

  logic [WCW-1:0] width_ext;
  logic [WCW-1:0] w_eff;
  logic [WCW-1:0] col_next;
  logic [HCW-1:0] height_ext;
  logic [HCW-1:0] h_eff;
  logic [HCW-1:0] row_next;
  logic           row_end;
  logic           frame_end;
  logic           is_pixel;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      width_in_use  <= rcpc_pkg::WIDTH_RESET;
      height_in_use <= rcpc_pkg::HEIGHT_RESET;
      lit_threshold <= rcpc_pkg::THRESHOLD_RESET;
      center_x      <= rcpc_pkg::CENTER_RESET;
      center_y      <= rcpc_pkg::CENTER_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rcpc_pkg::CFG_WIDTH:     width_in_use  <= cfg_data;
        rcpc_pkg::CFG_HEIGHT:    height_in_use <= cfg_data;
        rcpc_pkg::CFG_THRESHOLD: lit_threshold <= cfg_data[rcpc_pkg::PIX_W-1:0];
        rcpc_pkg::CFG_CENTER_X:  center_x      <= cfg_data[rcpc_pkg::CENTER_W-1:0];
        rcpc_pkg::CFG_CENTER_Y:  center_y      <= cfg_data[rcpc_pkg::CENTER_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp geometry and find row and frame ends
  always_comb begin
    width_ext  = WCW'(width_in_use);
    height_ext = HCW'(height_in_use);
    priority if (width_ext == '0)                  w_eff = WCW'(1);
    else if (width_ext > WCW'(MAX_WIDTH))          w_eff = WCW'(MAX_WIDTH);
    else                                           w_eff = width_ext;
    priority if (height_ext == '0)                 h_eff = HCW'(1);
    else if (height_ext > HCW'(MAX_HEIGHT))        h_eff = HCW'(MAX_HEIGHT);
    else                                           h_eff = height_ext;
    col_next  = WCW'(col_pos) + WCW'(1);
    row_next  = HCW'(row_pos) + HCW'(1);
    is_pixel  = (op == rcpc_pkg::OP_PIXEL);
    row_end   = is_pixel && (col_next >= w_eff);
    frame_end = row_end && (row_next >= h_eff);
  end

  // Classify the transaction for the back end
  always_comb begin
    entry.op        = op;
    entry.lit       = pixel > lit_threshold;
    entry.row_end   = row_end;
    entry.frame_end = frame_end;
    entry.upper     = YCW'(row_pos) < YCW'(center_y);
    entry.left      = XCW'(col_pos) < XCW'(center_x);
    entry.in_range  = WCW'(column_index) < WCW'(MAX_WIDTH);
    entry.row_index = rcpc_pkg::ROW_IDX_W'(row_pos);
    addr            = (op == rcpc_pkg::OP_READ) ? XW'(column_index) : col_pos;
  end

  // Advance the raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (accept) begin
      if (is_pixel) begin
        if (row_end) begin
          col_pos <= '0;
          row_pos <= frame_end ? '0 : YW'(row_next);
        end else begin
          col_pos <= XW'(col_next);
        end
      end else if (op == rcpc_pkg::OP_CLEAR) begin
        col_pos <= '0;
        row_pos <= '0;
      end
    end
  end

endmodule

### hdl/rcpc_queue.sv
module rcpc_queue #(
  parameter int AW = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rcpc_pkg::entry_t push_entry,
  input  logic [AW-1:0]    push_addr,
  input  logic             pop,
  output logic             head_valid,
  output rcpc_pkg::entry_t head_entry,
  output logic [AW-1:0]    head_addr,
  output logic             full
);

  rcpc_pkg::entry_t slot_entry [rcpc_pkg::QUEUE_DEPTH];
  logic [AW-1:0]    slot_addr  [rcpc_pkg::QUEUE_DEPTH];

  logic [rcpc_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [rcpc_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [rcpc_pkg::QUEUE_AW:0]   count;

  assign head_valid = (count != '0);
  assign full       = (count == (rcpc_pkg::QUEUE_AW + 1)'(rcpc_pkg::QUEUE_DEPTH));
  assign head_entry = slot_entry[rd_ptr];
  assign head_addr  = slot_addr[rd_ptr];

  // Store incoming transactions
  always_ff @(posedge clk) begin
    if (push) begin
      slot_entry[wr_ptr] <= push_entry;
      slot_addr[wr_ptr]  <= push_addr;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + rcpc_pkg::QUEUE_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + rcpc_pkg::QUEUE_AW'(1);
      unique case ({push, pop})
        2'b10:   count <= count + (rcpc_pkg::QUEUE_AW + 1)'(1);
        2'b01:   count <= count - (rcpc_pkg::QUEUE_AW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### hdl/rcpc_back.sv
`include "row_column_projection_counter_defines.svh"

module rcpc_back #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              head_valid,
  input  rcpc_pkg::entry_t                  head_entry,
  input  logic [$clog2(MAX_WIDTH)-1:0]      head_addr,
  output logic                              pop,
  output logic                              init_busy,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic                              row_done,
  output logic [rcpc_pkg::ROW_IDX_W-1:0]    row_index,
  output logic [rcpc_pkg::COUNT_W-1:0]      row_count,
  output logic                              frame_done,
  output logic [rcpc_pkg::COUNT_W-1:0]      column_count,
  output logic [rcpc_pkg::MASS_W-1:0]       upper_left_mass,
  output logic [rcpc_pkg::MASS_W-1:0]       upper_right_mass,
  output logic [rcpc_pkg::MASS_W-1:0]       total_mass,
  output logic [rcpc_pkg::COUNT_W-1:0]      row_peak,
  output logic [rcpc_pkg::COUNT_W-1:0]      column_peak
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam logic [XW-1:0] SWEEP_LAST = XW'(MAX_WIDTH - 1);

  // Column store
  logic [rcpc_pkg::COUNT_W-1:0] column_hist [MAX_WIDTH];

  // Execute stage
  logic                         b_valid;
  rcpc_pkg::entry_t             b_entry;
  logic [XW-1:0]                b_addr;
  logic [rcpc_pkg::COUNT_W-1:0] rdata;

  // Bypass of the last column write
  logic                         fwd_valid;
  logic [XW-1:0]                fwd_addr;
  logic [rcpc_pkg::COUNT_W-1:0] fwd_data;

  // Clearing pass
  logic          sweeping;
  logic [XW-1:0] sweep_cnt;

  // Accumulators
  logic [rcpc_pkg::COUNT_W-1:0] row_acc,   row_acc_next;
  logic [rcpc_pkg::MASS_W-1:0]  left_acc,  left_acc_next;
  logic [rcpc_pkg::MASS_W-1:0]  right_acc, right_acc_next;
  logic [rcpc_pkg::MASS_W-1:0]  total_acc, total_acc_next;
  logic [rcpc_pkg::COUNT_W-1:0] row_max,   row_max_next;
  logic [rcpc_pkg::COUNT_W-1:0] col_max,   col_max_next;

  logic                          out_free;
  logic                          b_fire;
  logic                          b_is_clear;
  logic                          b_load;
  logic                          pixel_wr;
  logic [rcpc_pkg::COUNT_W-1:0]  col_cur;
  logic [rcpc_pkg::COUNT_W-1:0]  col_new;
  logic [rcpc_pkg::COUNT_W-1:0]  row_inc;
  logic                          res_row_done;
  logic [rcpc_pkg::ROW_IDX_W-1:0] res_row_index;
  logic [rcpc_pkg::COUNT_W-1:0]  res_row_count;
  logic                          res_frame_done;
  logic [rcpc_pkg::COUNT_W-1:0]  res_column_count;

  // Stage handshakes
  always_comb begin
    out_free   = !result_valid || !result_stall;
    b_fire     = b_valid && out_free;
    b_is_clear = (b_entry.op == rcpc_pkg::OP_CLEAR);
    b_load     = head_valid && !sweeping && (!b_valid || (b_fire && !b_is_clear));
    pop        = b_load;
    col_cur    = (fwd_valid && (fwd_addr == b_addr)) ? fwd_data : rdata;
    col_new    = rcpc_pkg::sat_count(col_cur);
    row_inc    = b_entry.lit ? rcpc_pkg::sat_count(row_acc) : row_acc;
    pixel_wr   = b_fire && (b_entry.op == rcpc_pkg::OP_PIXEL) && b_entry.lit;
  end

  // Work out the effect of the transaction in the execute stage
  always_comb begin
    row_acc_next     = row_acc;
    left_acc_next    = left_acc;
    right_acc_next   = right_acc;
    total_acc_next   = total_acc;
    row_max_next     = row_max;
    col_max_next     = col_max;
    res_row_done     = 1'b0;
    res_row_index    = '0;
    res_row_count    = '0;
    res_frame_done   = 1'b0;
    res_column_count = '0;
    unique case (b_entry.op)
      rcpc_pkg::OP_PIXEL: begin
        if (b_entry.lit) begin
          if (col_new > col_max) col_max_next = col_new;
          total_acc_next = rcpc_pkg::sat_mass(total_acc);
          if (b_entry.upper) begin
            if (b_entry.left) left_acc_next  = rcpc_pkg::sat_mass(left_acc);
            else              right_acc_next = rcpc_pkg::sat_mass(right_acc);
          end
        end
        if (b_entry.row_end) begin
          res_row_done   = 1'b1;
          res_row_index  = b_entry.row_index;
          res_row_count  = row_inc;
          res_frame_done = b_entry.frame_end;
          if (row_inc > row_max) row_max_next = row_inc;
          row_acc_next   = '0;
        end else begin
          row_acc_next   = row_inc;
        end
      end
      rcpc_pkg::OP_CLEAR: begin
        row_acc_next   = '0;
        left_acc_next  = '0;
        right_acc_next = '0;
        total_acc_next = '0;
        row_max_next   = '0;
        col_max_next   = '0;
      end
      rcpc_pkg::OP_READ: begin
        if (b_entry.in_range) res_column_count = col_cur;
      end
      default: ;
    endcase
  end

  // Write and read the column store
  always_ff @(posedge clk) begin
    if (sweeping) begin
      column_hist[sweep_cnt] <= '0;
    end else if (pixel_wr) begin
      column_hist[b_addr] <= col_new;
    end
    if (b_load) begin
      rdata <= column_hist[head_addr];
    end
  end

  // Load the execute stage
  always_ff @(posedge clk) begin
    if (b_load) begin
      b_entry <= head_entry;
      b_addr  <= head_addr;
    end
  end

  // Control: execute valid, clearing pass, bypass
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      sweeping  <= 1'b1;
      init_busy <= 1'b1;
      sweep_cnt <= '0;
      fwd_valid <= 1'b0;
    end else begin
      if (b_load)      b_valid <= 1'b1;
      else if (b_fire) b_valid <= 1'b0;
      if (sweeping) begin
        sweep_cnt <= sweep_cnt + XW'(1);
        if (sweep_cnt == SWEEP_LAST) begin
          sweeping  <= 1'b0;
          init_busy <= 1'b0;
          sweep_cnt <= '0;
        end
      end else if (b_fire && b_is_clear) begin
        sweeping <= 1'b1;
      end
      if (sweeping) begin
        fwd_valid <= 1'b0;
      end else if (pixel_wr) begin
        fwd_valid <= 1'b1;
      end
    end
  end

  // Hold the bypass data alongside the write
  always_ff @(posedge clk) begin
    if (pixel_wr) begin
      fwd_addr <= b_addr;
      fwd_data <= col_new;
    end
  end

  // Commit accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      row_acc   <= '0;
      left_acc  <= '0;
      right_acc <= '0;
      total_acc <= '0;
      row_max   <= '0;
      col_max   <= '0;
    end else if (b_fire) begin
      row_acc   <= row_acc_next;
      left_acc  <= left_acc_next;
      right_acc <= right_acc_next;
      total_acc <= total_acc_next;
      row_max   <= row_max_next;
      col_max   <= col_max_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (b_fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      row_done         <= res_row_done;
      row_index        <= res_row_index;
      row_count        <= res_row_count;
      frame_done       <= res_frame_done;
      column_count     <= res_column_count;
      upper_left_mass  <= left_acc_next;
      upper_right_mass <= right_acc_next;
      total_mass       <= total_acc_next;
      row_peak         <= row_max_next;
      column_peak      <= col_max_next;
    end
  end

  `RCPC_ASSERT(a_sweep_stage_empty, sweeping |-> !b_valid, "transaction in execute stage during sweep")
  `RCPC_ASSERT(a_fire_fills_output, b_fire |=> result_valid, "fired transaction missing at output")
  `RCPC_ASSERT(a_init_within_sweep, init_busy |-> sweeping, "start-up busy without sweep")
  `RCPC_ASSERT_ALWAYS(a_row_acc_bound, rst || (row_acc <= rcpc_pkg::COUNT_SAT), "row count above limit")

endmodule

### hdl/row_column_projection_counter.sv
// A transaction accepted passes through the queue, the execute stage and the output register.
// Throughput: one pixel or column read per cycle unless result_stall, a full queue or a sweep
// holds it; the column store is read and written in a two-stage loop with a bypass.
// A clear sweeps the store. Reset: the same sweep zeroes it; item_stall stays high until it ends.
// Configuration registers return to their defaults on reset and are always ready.
module row_column_projection_counter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rcpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rcpc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic [rcpc_pkg::OP_W-1:0]           op,
  input  logic [rcpc_pkg::PIX_W-1:0]          pixel,
  input  logic [rcpc_pkg::COL_IDX_W-1:0]      column_index,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic                                row_done,
  output logic [rcpc_pkg::ROW_IDX_W-1:0]      row_index,
  output logic [rcpc_pkg::COUNT_W-1:0]        row_count,
  output logic                                frame_done,
  output logic [rcpc_pkg::COUNT_W-1:0]        column_count,
  output logic [rcpc_pkg::MASS_W-1:0]         upper_left_mass,
  output logic [rcpc_pkg::MASS_W-1:0]         upper_right_mass,
  output logic [rcpc_pkg::MASS_W-1:0]         total_mass,
  output logic [rcpc_pkg::COUNT_W-1:0]        row_peak,
  output logic [rcpc_pkg::COUNT_W-1:0]        column_peak
);

  localparam int XW = $clog2(MAX_WIDTH);

  rcpc_pkg::entry_t front_entry;
  logic [XW-1:0]    front_addr;
  rcpc_pkg::entry_t head_entry;
  logic [XW-1:0]    head_addr;
  logic             head_valid;
  logic             queue_full;
  logic             pop;
  logic             init_busy;
  logic             accept;

  // Hold off input while the queue is full or the store is being set up
  assign cfg_ready  = 1'b1;
  assign item_stall = queue_full | init_busy;
  assign accept     = item_valid & ~item_stall;

  rcpc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid & cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .op           (op),
    .pixel        (pixel),
    .column_index (column_index),
    .entry        (front_entry),
    .addr         (front_addr)
  );

  rcpc_queue #(
    .AW (XW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_entry (front_entry),
    .push_addr  (front_addr),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .head_addr  (head_addr),
    .full       (queue_full)
  );

  rcpc_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .head_valid       (head_valid),
    .head_entry       (head_entry),
    .head_addr        (head_addr),
    .pop              (pop),
    .init_busy        (init_busy),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .row_done         (row_done),
    .row_index        (row_index),
    .row_count        (row_count),
    .frame_done       (frame_done),
    .column_count     (column_count),
    .upper_left_mass  (upper_left_mass),
    .upper_right_mass (upper_right_mass),
    .total_mass       (total_mass),
    .row_peak         (row_peak),
    .column_peak      (column_peak)
  );

endmodule
